### rtl/olad_pkg.sv
// ----------------------------------------------------------------------------
// olad_pkg
// Shared types and constants for the ordered list block: list capacity,
// index widths, command and status codes, item structs and memory request.
// ----------------------------------------------------------------------------
`default_nettype none

package olad_pkg;

  // List capacity and the widths that follow from it.
  localparam int unsigned Capacity = 32;
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned DW = 32;

  // Command codes; the fourth code is unused and ignored.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_ENTRY     = 3'd5
  } status_e;

  // One input item.
  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [DW-1:0] value;
  } olad_req_t;

  // One result item.
  typedef struct packed {
    status_e              status;
    logic signed [DW-1:0] entry_value;
    logic                 last;
  } olad_res_t;

  // Access request to the entry memory.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } olad_mem_req_t;

endpackage

`default_nettype wire

### rtl/ordered_list_append_delete_dump.sv
// ----------------------------------------------------------------------------
// ordered_list_append_delete_dump
// Bounded ordered list of signed 32-bit values with append, delete of the
// first match, and dump of all entries in order.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Append, and any
// command on an empty list, is done in the cycle it is taken and busy_o
// stays low. Delete and dump walk the entry memory one entry per cycle, with
// busy_o high for the walk (one memory read per cycle sets this rate).
// Each result appears on res_o for exactly one cycle with strobe_o high, in
// the cycle after it is formed; the receiver cannot stall, so it must take
// every strobe. A dump of N entries, N > 0, gives N results, the last one
// flagged; other commands give one result; code 3 is ignored and gives none.
`default_nettype none

module ordered_list_append_delete_dump
  import olad_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire olad_req_t req_i,
  output logic           busy_o,
  output logic           strobe_o,
  output olad_res_t      res_o
);

  olad_mem_req_t mem_req;
  logic [DW-1:0] mem_rdata;
  logic          res_valid;
  olad_res_t     res;
  logic          strobe_q;
  olad_res_t     res_q;

  olad_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  olad_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: the strobe is control, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

`default_nettype wire

### rtl/olad_store.sv
// ----------------------------------------------------------------------------
// olad_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module olad_store
  import olad_pkg::*;
(
  input  wire logic          clk_i,
  input  wire olad_mem_req_t req_i,
  output logic [DW-1:0]      rdata_o
);

  logic [DW-1:0] mem [Capacity];
  logic [DW-1:0] rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/olad_seq.sv
// ----------------------------------------------------------------------------
// olad_seq
// Command sequencer: holds the entry count, walks the entry memory one
// address per cycle for search, compaction and dump, and forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module olad_seq
  import olad_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire olad_req_t     req_i,
  output logic               busy_o,
  output olad_mem_req_t      mem_o,
  input  wire logic [DW-1:0] rdata_i,
  output logic               res_valid_o,
  output olad_res_t          res_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DUMP  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [DW-1:0] key_q, key_d;

  logic          accept;
  logic [CW-1:0] last_idx;
  logic          at_last;
  logic [AW-1:0] ptr_inc;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign last_idx = count_q - CW'(1);
  assign at_last  = (CW'(ptr_q) == last_idx);
  assign ptr_inc  = ptr_q + AW'(1);

  // Next-state logic. The read data in a walking state always belongs to the
  // entry at ptr_q; the read of the following entry is issued alongside.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    key_d       = key_q;
    mem_o       = '0;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_APPENDED, entry_value: '0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = req_i.value;
          ptr_d = '0;
          if (req_i.cmd == CMD_APPEND) begin
            res_valid_o = 1'b1;
            if (count_q == CW'(Capacity)) begin
              res_o.status = ST_FULL;
            end else begin
              mem_o.we     = 1'b1;
              mem_o.waddr  = AW'(count_q);
              mem_o.wdata  = req_i.value;
              count_d      = count_q + CW'(1);
              res_o.status = ST_APPENDED;
            end
          end else if (req_i.cmd == CMD_DELETE || req_i.cmd == CMD_DUMP) begin
            if (count_q == '0) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_EMPTY;
            end else begin
              // Fetch the head entry.
              mem_o.re    = 1'b1;
              mem_o.raddr = '0;
              state_d     = (req_i.cmd == CMD_DELETE) ? S_SRCH : S_DUMP;
            end
          end
        end
      end

      S_SRCH: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = ptr_inc;
        if (rdata_i == key_q) begin
          if (at_last) begin
            // Match on the tail entry: nothing to move.
            count_d      = count_q - CW'(1);
            res_valid_o  = 1'b1;
            res_o.status = ST_DELETED;
            state_d      = S_IDLE;
          end else begin
            ptr_d   = ptr_inc;
            state_d = S_SHIFT;
          end
        end else if (at_last) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          ptr_d = ptr_inc;
        end
      end

      S_SHIFT: begin
        // Move each following entry down by one place.
        mem_o.we    = 1'b1;
        mem_o.waddr = ptr_q - AW'(1);
        mem_o.wdata = rdata_i;
        mem_o.re    = 1'b1;
        mem_o.raddr = ptr_inc;
        ptr_d       = ptr_inc;
        if (at_last) begin
          count_d      = count_q - CW'(1);
          res_valid_o  = 1'b1;
          res_o.status = ST_DELETED;
          state_d      = S_IDLE;
        end
      end

      S_DUMP: begin
        mem_o.re          = 1'b1;
        mem_o.raddr       = ptr_inc;
        ptr_d             = ptr_inc;
        res_valid_o       = 1'b1;
        res_o.status      = ST_ENTRY;
        res_o.entry_value = rdata_i;
        res_o.last        = at_last;
        if (at_last) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Walk pointer and search key.
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    key_q <= key_d;
  end

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Capacity))
    else $error("entry count above capacity");

  // A walk only runs over a non-empty list.
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (count_q != '0))
    else $error("walking an empty list");

  // Writes stay within the held entries or the next free place.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> (CW'(mem_o.waddr) <= count_q))
    else $error("write beyond the list tail");

  // The final result of an item leaves the sequencer idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !busy_o)
    else $error("busy after final result");

  // A result that is not final is followed by more work.
  a_more_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> busy_o)
    else $error("idle before final result");

endmodule

`default_nettype wire
